[rtl/core/whcp_pkg.sv]
// ----------------------------------------------------------------------------
// whcp_pkg
// Types and constants shared by the WAV header chunk parser.
// ----------------------------------------------------------------------------
package whcp_pkg;

   // Tags and chunk ids as little-endian words, byte 0 lowest
   localparam logic [31:0] RIFF_TAG = 32'h4646_4952;
   localparam logic [31:0] WAVE_TAG = 32'h4556_4157;
   localparam logic [31:0] ID_FMT   = 32'h2074_6D66;
   localparam logic [31:0] ID_DATA  = 32'h6174_6164;
   localparam logic [31:0] FMT_LEN  = 32'd16;

   typedef enum logic [2:0] {
      PH_RIFF  = 3'd0,
      PH_CHUNK = 3'd1,
      PH_FMT   = 3'd2,
      PH_SKIP  = 3'd3,
      PH_DONE  = 3'd4
   } whcp_phase_type;

   typedef enum logic [2:0] {
      ST_DATA      = 3'd0,
      ST_END_FMT   = 3'd1,
      ST_NOT_WAVE  = 3'd2,
      ST_FMT_SHORT = 3'd3,
      ST_TRUNCATED = 3'd4,
      ST_NO_FMT    = 3'd5
   } whcp_status_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] audio_format;
      logic [15:0] channel_count;
      logic [31:0] samples_per_sec;
      logic [31:0] bytes_per_sec;
      logic [15:0] frame_bytes;
      logic [15:0] sample_bits;
   } whcp_result_type;

   typedef struct packed {
      logic            valid;
      whcp_result_type data;
   } whcp_emit_type;

endpackage

[rtl/core/whcp_req_if.sv]
// ----------------------------------------------------------------------------
// whcp_req_if
// Byte stream channel: one file byte per beat, with a final-byte flag.
// ----------------------------------------------------------------------------
interface whcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       end_of_stream;

   modport source (output valid, output byte_value, output end_of_stream, input ready);
   modport sink   (input valid, input byte_value, input end_of_stream, output ready);
endinterface

[rtl/core/whcp_rsp_if.sv]
// ----------------------------------------------------------------------------
// whcp_rsp_if
// Result channel: status and format fields, one beat per stream.
// ----------------------------------------------------------------------------
interface whcp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] audio_format;
   logic [15:0] channel_count;
   logic [31:0] samples_per_sec;
   logic [31:0] bytes_per_sec;
   logic [15:0] frame_bytes;
   logic [15:0] sample_bits;

   modport source (
      output valid, output status, output audio_format, output channel_count,
      output samples_per_sec, output bytes_per_sec, output frame_bytes,
      output sample_bits, input ready
   );
   modport sink (
      input valid, input status, input audio_format, input channel_count,
      input samples_per_sec, input bytes_per_sec, input frame_bytes,
      input sample_bits, output ready
   );
endinterface

[rtl/core/whcp_parser.sv]
// ----------------------------------------------------------------------------
// whcp_parser
// Parse state and per-byte next-state logic; flags at most one result a byte.
// ----------------------------------------------------------------------------
module whcp_parser
   import whcp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    byte_value,
   input  logic          end_of_stream,
   output whcp_emit_type emit
);

   whcp_phase_type phase_ff, phase_in;
   logic [3:0]     idx_ff, idx_in;
   logic [55:0]    hdr_ff, hdr_in;
   logic           riff_ok_ff, riff_ok_in;
   logic [31:0]    skip_ff, skip_in;
   logic           pad_ff, pad_in;
   logic           fmt_seen_ff, fmt_seen_in;
   logic [127:0]   fmt_ff, fmt_in;

   logic            fire;
   whcp_status_type fire_status;
   logic            mismatch;
   logic [31:0]     chunk_id;
   logic [31:0]     chunk_size;

   assign chunk_id   = hdr_ff[31:0];
   assign chunk_size = {byte_value, hdr_ff[55:32]};

   // Next state
   always_comb begin
      phase_in    = phase_ff;
      idx_in      = idx_ff;
      hdr_in      = hdr_ff;
      riff_ok_in  = riff_ok_ff;
      skip_in     = skip_ff;
      pad_in      = pad_ff;
      fmt_seen_in = fmt_seen_ff;
      fmt_in      = fmt_ff;
      fire        = 1'b0;
      fire_status = ST_DATA;
      mismatch    = 1'b0;

      unique case (phase_ff)
         PH_RIFF: begin
            if (idx_ff < 4'd4) begin
               mismatch = byte_value != RIFF_TAG[{idx_ff[1:0], 3'b000} +: 8];
            end else if (idx_ff >= 4'd8) begin
               mismatch = byte_value != WAVE_TAG[{idx_ff[1:0], 3'b000} +: 8];
            end
            riff_ok_in = riff_ok_ff & ~mismatch;
            if (idx_ff == 4'd11) begin
               idx_in = 4'd0;
               if (!riff_ok_in) begin
                  fire        = 1'b1;
                  fire_status = ST_NOT_WAVE;
               end else begin
                  phase_in = PH_CHUNK;
               end
            end else begin
               idx_in = idx_ff + 4'd1;
            end
         end
         PH_CHUNK: begin
            if (idx_ff[2:0] == 3'd7) begin
               idx_in = 4'd0;
               pad_in = chunk_size[0];
               if (chunk_id == ID_FMT) begin
                  if (chunk_size < FMT_LEN) begin
                     fire        = 1'b1;
                     fire_status = ST_FMT_SHORT;
                  end else begin
                     skip_in  = chunk_size - FMT_LEN;
                     phase_in = PH_FMT;
                  end
               end else if (chunk_id == ID_DATA && fmt_seen_ff) begin
                  fire        = 1'b1;
                  fire_status = ST_DATA;
               end else begin
                  skip_in  = chunk_size;
                  phase_in = (chunk_size != 32'd0 || chunk_size[0]) ? PH_SKIP : PH_CHUNK;
               end
            end else begin
               hdr_in[{idx_ff[2:0], 3'b000} +: 8] = byte_value;
               idx_in = idx_ff + 4'd1;
            end
         end
         PH_FMT: begin
            fmt_in[{idx_ff, 3'b000} +: 8] = byte_value;
            if (idx_ff == 4'd15) begin
               idx_in      = 4'd0;
               fmt_seen_in = 1'b1;
               phase_in    = (skip_ff != 32'd0 || pad_ff) ? PH_SKIP : PH_CHUNK;
            end else begin
               idx_in = idx_ff + 4'd1;
            end
         end
         PH_SKIP: begin
            if (skip_ff != 32'd0) begin
               skip_in = skip_ff - 32'd1;
            end else begin
               pad_in = 1'b0;
            end
            if (skip_in == 32'd0 && !pad_in) begin
               phase_in = PH_CHUNK;
            end
         end
         default: begin
         end
      endcase

      if (fire) begin
         phase_in = PH_DONE;
      end

      // End of stream: report where parsing stopped if no result is out yet, then start over
      if (end_of_stream) begin
         if (!fire && phase_in != PH_DONE) begin
            fire = 1'b1;
            if (phase_in == PH_RIFF || phase_in == PH_FMT) begin
               fire_status = ST_TRUNCATED;
            end else begin
               fire_status = fmt_seen_in ? ST_END_FMT : ST_NO_FMT;
            end
         end
         phase_in    = PH_RIFF;
         idx_in      = 4'd0;
         riff_ok_in  = 1'b1;
         skip_in     = 32'd0;
         pad_in      = 1'b0;
         fmt_seen_in = 1'b0;
      end
   end

   // Result
   always_comb begin
      emit.valid = accept & fire;
      emit.data  = '0;
      emit.data.status = fire_status;
      if (fire_status == ST_DATA || fire_status == ST_END_FMT) begin
         emit.data.audio_format    = fmt_in[15:0];
         emit.data.channel_count   = fmt_in[31:16];
         emit.data.samples_per_sec = fmt_in[63:32];
         emit.data.bytes_per_sec   = fmt_in[95:64];
         emit.data.frame_bytes     = fmt_in[111:96];
         emit.data.sample_bits     = fmt_in[127:112];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_RIFF;
         idx_ff      <= 4'd0;
         riff_ok_ff  <= 1'b1;
         skip_ff     <= 32'd0;
         pad_ff      <= 1'b0;
         fmt_seen_ff <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         idx_ff      <= idx_in;
         riff_ok_ff  <= riff_ok_in;
         skip_ff     <= skip_in;
         pad_ff      <= pad_in;
         fmt_seen_ff <= fmt_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hdr_ff <= hdr_in;
         fmt_ff <= fmt_in;
      end
   end

endmodule

[rtl/core/whcp_out_reg.sv]
// ----------------------------------------------------------------------------
// whcp_out_reg
// Result register; holds a beat until the sink takes it.
// ----------------------------------------------------------------------------
module whcp_out_reg
   import whcp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  whcp_emit_type emit,
   output logic          space,
   whcp_rsp_if.source    rsp_bus
);

   logic            valid_ff;
   whcp_result_type data_ff;

   assign space = ~valid_ff | rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (space) begin
         valid_ff <= emit.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (space && emit.valid) begin
         data_ff <= emit.data;
      end
   end

   assign rsp_bus.valid           = valid_ff;
   assign rsp_bus.status          = data_ff.status;
   assign rsp_bus.audio_format    = data_ff.audio_format;
   assign rsp_bus.channel_count   = data_ff.channel_count;
   assign rsp_bus.samples_per_sec = data_ff.samples_per_sec;
   assign rsp_bus.bytes_per_sec   = data_ff.bytes_per_sec;
   assign rsp_bus.frame_bytes     = data_ff.frame_bytes;
   assign rsp_bus.sample_bits     = data_ff.sample_bits;

endmodule

[rtl/core/wav_header_chunk_parser.sv]
// ----------------------------------------------------------------------------
// wav_header_chunk_parser
// RIFF/WAVE header and chunk walker: one file byte per beat in, one result
// beat per stream out (status plus the captured format fields).
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, sustained, as long as the result side drains.
// Latency: a result appears on rsp_bus the cycle after the byte that decides it.
// The only stall: a held result that the sink has not taken blocks the next byte.
// Reset: synchronous, active high; clears the parse state and the result slot.
// A byte with end_of_stream set also returns the parser to the header phase.
// ----------------------------------------------------------------------------
module wav_header_chunk_parser
   import whcp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   whcp_req_if.sink   req_bus,
   whcp_rsp_if.source rsp_bus
);

   logic          accept;
   logic          space;
   whcp_emit_type emit;

   // Take a byte whenever the result slot is free or drains this cycle; hold
   // off the next byte while a finished result waits for the sink.
   assign req_bus.ready = space;
   assign accept        = req_bus.valid & space;

   // Parse state: header check, chunk header gather, format capture, skip count
   whcp_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .byte_value    (req_bus.byte_value),
      .end_of_stream (req_bus.end_of_stream),
      .emit          (emit)
   );

   // Hold the result beat until the sink takes it
   whcp_out_reg u_out_reg (
      .clock   (clock),
      .reset   (reset),
      .emit    (emit),
      .space   (space),
      .rsp_bus (rsp_bus)
   );

endmodule
